/* hw/rtl/lst_pkg.sv */
// Shared types, constants and codes of the LCD scanline timing and status block.
package lst_pkg;

  // Line and frame timing, in dots and lines.
  localparam logic [10:0] DotsToHblank    = 11'd1006;
  localparam logic [10:0] DotsPerLine     = 11'd1232;
  localparam logic [7:0]  LinesPerFrame   = 8'd228;
  localparam logic [7:0]  FirstVblankLine = 8'd160;
  localparam logic [7:0]  LastVblankLine  = 8'd226;

  // Status bits 0 to 2 are owned by the timing logic and cannot be written.
  localparam logic [15:0] RoStatusMask = 16'h0007;
  localparam int unsigned StVblankBit  = 0;
  localparam int unsigned StHblankBit  = 1;
  localparam int unsigned StMatchBit   = 2;

  // Command codes.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Register select codes.
  localparam logic [1:0] SEL_CTRL = 2'd0;
  localparam logic [1:0] SEL_STAT = 2'd1;
  localparam logic [1:0] SEL_LINE = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] reg_select;
    logic       byte_lane;
    logic [7:0] write_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [7:0] line_number;
    logic       hblank_flag;
    logic       vblank_flag;
    logic       line_match_flag;
    logic       draw_request;
    logic       frame_start;
  } out_word_t;

  typedef struct packed {
    logic [10:0] dot_counter;
    logic [7:0]  current_line;
    logic [15:0] control_word;
    logic [15:0] status_word;
  } timing_state_t;

endpackage

/* hw/rtl/lst_channels.sv */
// Valid/ready channel interfaces for the input and result words.
interface lst_in_if;
  import lst_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lst_out_if;
  import lst_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/lcd_scanline_timing_status.sv */
// Top level of the LCD scanline timing and status block.
//
// Each input word is a dot tick, a register byte write or a register byte
// read. Every input word produces exactly one result word, which carries the
// read byte, the current line, the blank and match status bits, and the
// draw-request and frame-start pulses after that word.
// Words enter through an input register; the timing and register logic runs
// between that register and the result register, which holds each result
// word until the receiver takes it. One word is accepted per cycle while the
// receiver keeps taking results.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word, so in_ch.ready drops only once both
// are full. Nothing is lost or repeated across a stall.
// Synchronous active-low reset clears the dot counter, the line, the control
// and status registers and both valid flags.
module lcd_scanline_timing_status (
  input  logic      clk,
  input  logic      rst_n,
  lst_in_if.sink    in_ch,
  lst_out_if.source out_ch
);
  import lst_pkg::*;

  logic          in_v_r;
  in_word_t      in_data_r;
  logic          out_v_r;
  out_word_t     out_data_r;
  timing_state_t st_r;
  timing_state_t st_nxt;
  out_word_t     result;
  logic          advance;

  // The input stage moves on when the result register is free or being emptied.
  assign advance     = !out_v_r || out_ch.ready;
  assign in_ch.ready = !in_v_r || advance;

  lst_step u_step (
    .st_cur (st_r),
    .item   (in_data_r),
    .st_nxt (st_nxt),
    .result (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_data_r <= in_ch.data;
    end
  end

  // Timing and register state updates as each word leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_v_r && advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v_r && advance) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_data_r;

  // The dot counter and the line always stay within one line and one frame.
  a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.dot_counter < DotsPerLine)
    else $error("dot counter out of range");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.current_line < LinesPerFrame)
    else $error("line out of range");

  // A frame start lands on the first blank line and never with a draw request.
  a_frame_vblank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_data_r.frame_start) |->
      (out_data_r.vblank_flag && !out_data_r.draw_request &&
       out_data_r.line_number == FirstVblankLine))
    else $error("frame start without vertical blank");

  // A draw request is only raised for a visible line, as blank begins.
  a_draw_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_data_r.draw_request) |->
      (out_data_r.hblank_flag && out_data_r.line_number < FirstVblankLine))
    else $error("draw request outside a visible line");

endmodule

/* hw/rtl/lst_step.sv */
// Next-state and result logic for one word: dot/line timing and register access.
module lst_step (
  input  lst_pkg::timing_state_t st_cur,
  input  lst_pkg::in_word_t      item,
  output lst_pkg::timing_state_t st_nxt,
  output lst_pkg::out_word_t     result
);
  import lst_pkg::*;

  // Replace one byte lane of a 16-bit register.
  function automatic logic [15:0] put_lane(input logic [15:0] word, input logic lane,
                                           input logic [7:0] b);
    logic [15:0] res;
    res = word;
    if (lane) begin
      res[15:8] = b;
    end else begin
      res[7:0] = b;
    end
    return res;
  endfunction

  always_comb begin
    logic [10:0] dot_inc;
    logic [7:0]  line_inc;
    logic [15:0] st_written;
    logic [7:0]  rd;
    logic        draw;
    logic        frame;

    st_nxt     = st_cur;
    dot_inc    = st_cur.dot_counter + 11'd1;
    line_inc   = st_cur.current_line + 8'd1;
    st_written = put_lane(st_cur.status_word, item.byte_lane, item.write_byte);
    rd         = '0;
    draw       = 1'b0;
    frame      = 1'b0;

    unique case (item.command)
      CMD_TICK: begin
        // Horizontal blank starts part-way through the line.
        if (dot_inc == DotsToHblank) begin
          st_nxt.status_word[StHblankBit] = 1'b1;
          draw = (st_cur.current_line < FirstVblankLine);
        end
        // End of line: advance the line and refresh the status bits.
        if (dot_inc >= DotsPerLine) begin
          if (line_inc >= LinesPerFrame) begin
            line_inc = '0;
          end
          st_nxt.current_line = line_inc;
          dot_inc = '0;
          st_nxt.status_word[StHblankBit] = 1'b0;
          st_nxt.status_word[StVblankBit] =
            (line_inc >= FirstVblankLine) && (line_inc <= LastVblankLine);
          st_nxt.status_word[StMatchBit] = (line_inc == st_cur.status_word[15:8]);
          frame = (line_inc == FirstVblankLine);
        end
        st_nxt.dot_counter = dot_inc;
      end
      CMD_WRITE: begin
        unique case (item.reg_select)
          SEL_CTRL: begin
            st_nxt.control_word =
              put_lane(st_cur.control_word, item.byte_lane, item.write_byte);
          end
          SEL_STAT: begin
            st_nxt.status_word = (st_written & ~RoStatusMask) |
                                 (st_cur.status_word & RoStatusMask);
          end
          default: ;
        endcase
      end
      CMD_READ: begin
        unique case (item.reg_select)
          SEL_CTRL: rd = item.byte_lane ? st_cur.control_word[15:8] : st_cur.control_word[7:0];
          SEL_STAT: rd = item.byte_lane ? st_cur.status_word[15:8] : st_cur.status_word[7:0];
          SEL_LINE: rd = item.byte_lane ? 8'd0 : st_cur.current_line;
          default:  rd = '0;
        endcase
      end
      default: ;
    endcase

    // Result word reflects the state after this word.
    result.read_byte       = rd;
    result.line_number     = st_nxt.current_line;
    result.hblank_flag     = st_nxt.status_word[StHblankBit];
    result.vblank_flag     = st_nxt.status_word[StVblankBit];
    result.line_match_flag = st_nxt.status_word[StMatchBit];
    result.draw_request    = draw;
    result.frame_start     = frame;
  end

endmodule
